// File: src/assert_macros.svh
// Assertion macros shared by the defective pixel correction RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define DPNA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication.
`define DPNA_ASSERT_IMPL(label, ante, cons, msg) \
  `DPNA_ASSERT(label, ante |-> cons, msg)

// Next-cycle implication.
`define DPNA_ASSERT_NEXT(label, ante, cons, msg) \
  `DPNA_ASSERT(label, ante |=> cons, msg)

`endif

// File: src/dpna_pkg.sv
// Types, constants and the reciprocal table of the defective pixel correction block.
// Depends on nothing; used by every module of the block.
package dpna_pkg;

  localparam int PIX_W      = 9;
  localparam int ROW_W      = 12;
  localparam int COL_OUT_W  = 10;
  localparam int ROWS_CFG_W = 13;
  localparam int COLS_CFG_W = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_LIMIT  = 4096;

  // 3x3 window, entry index is row * 3 + column, column 2 is the newest.
  localparam int WIN_N = 9;
  localparam int WIN_UP_NEW   = 2;
  localparam int WIN_CENTER   = 4;
  localparam int WIN_MID_NEW  = 5;
  localparam int WIN_BOT_PREV = 7;
  localparam int WIN_BOT_NEW  = 8;

  localparam int SUM_W   = 12;
  localparam int CNT_W   = 4;
  localparam int RECIP_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLUMNS = 4'd1;

  // Result slots of one input pixel, in emission order.
  localparam int RES_N = 4;
  localparam logic [1:0] RES_CENTER   = 2'd0;
  localparam logic [1:0] RES_RIGHT    = 2'd1;
  localparam logic [1:0] RES_BOTTOM   = 2'd2;
  localparam logic [1:0] RES_LAST     = 2'd3;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_N-1:0] win_t;
  typedef logic [RES_N-1:0] pend_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

  // floor(2^16 / n), one below for n = 1, zero above 8; the quotient is corrected upward.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      4'd1: m = 16'hFFFF;
      4'd2: m = 16'd32768;
      4'd3: m = 16'd21845;
      4'd4: m = 16'd16384;
      4'd5: m = 16'd13107;
      4'd6: m = 16'd10922;
      4'd7: m = 16'd9362;
      4'd8: m = 16'd8192;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: src/dpna_line_store.sv
// One line store of the defective pixel correction block: a single-port-write,
// single-port-read synchronous RAM with registered read data. Uses dpna_pkg.
module dpna_line_store import dpna_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  pix_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output pix_t          rdata
);

  pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/dpna_mean.sv
// Mean of the strictly positive pixels of a 3x3 window, two register stages deep.
// Uses dpna_pkg for the window type and the reciprocal table.
module dpna_mean import dpna_pkg::*; (
  input  logic clk,
  input  win_t win,
  output pix_t mean
);

  logic [SUM_W-1:0] sum_nxt, sum_r, sum2_r;
  logic [CNT_W-1:0] cnt_nxt, cnt_r, cnt2_r;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic [SUM_W-1:0] q_r, qp1, mean_w;
  logic [SUM_W+CNT_W-1:0] chk;

  always_comb begin
    sum_nxt = '0;
    cnt_nxt = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (!win[i][PIX_W-1] && (win[i] != '0)) begin
        sum_nxt = sum_nxt + SUM_W'(win[i][PIX_W-2:0]);
        cnt_nxt = cnt_nxt + CNT_W'(1);
      end
    end
  end

  // Quotient by reciprocal, may come out one low.
  assign prod = {{RECIP_W{1'b0}}, sum_r} * {{SUM_W{1'b0}}, recip(cnt_r)};

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    sum2_r <= sum_r;
    cnt2_r <= cnt_r;
    q_r    <= prod[SUM_W+RECIP_W-1:RECIP_W];
  end

  assign qp1 = q_r + SUM_W'(1);
  assign chk = {{CNT_W{1'b0}}, qp1} * {{SUM_W{1'b0}}, cnt2_r};

  always_comb begin
    if (cnt2_r == '0) begin
      mean_w = '0;
    end else if (chk <= {{CNT_W{1'b0}}, sum2_r}) begin
      mean_w = qp1;
    end else begin
      mean_w = q_r;
    end
  end

  assign mean = pix_t'({1'b0, mean_w[PIX_W-2:0]});

endmodule

// File: src/defective_pixel_neighbour_average.sv
// Defective pixel correction over a 3x3 window; top level, uses dpna_pkg,
// dpna_line_store, dpna_mean and assert_macros.svh.
// The sequencer takes one pixel at a time through line store read, window shift, positive
// sum, reciprocal multiply and emit; emit waits while the output stalls and issues the
// extra results at row ends. The first result of a pixel is loaded in the EMIT state.
// Reset: synchronous, active low; counters and window cleared, both sizes set to 1.
`include "assert_macros.svh"

module defective_pixel_neighbour_average import dpna_pkg::*; #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_t                  in_pixel_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pix_t                  out_pixel_out,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_OUT_W-1:0]  out_column,
  output logic                  out_frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam logic [COLS_CFG_W+1:0] MAX_COLS_WIDE = (COLS_CFG_W + 2)'(MAX_COLUMNS);

  // Sequencer state and frame position.
  state_t state_r, state_nxt;
  pend_t  pend_r, pend_nxt, pend_new;
  logic   load;
  logic [1:0] slot;

  logic [ROWS_CFG_W-1:0] rows_cfg_r;
  logic [COLS_CFG_W-1:0] cols_cfg_r;
  logic [ROW_W-1:0]      rows_m1, row_cnt_r, r_r;
  logic [CW-1:0]         cols_m1, col_cnt_r, c_r;

  logic in_acc, cfg_wr, cfg_hit, out_free, interior_r;
  pix_t px_r, up_rd, mid_rd, mean;
  win_t win_r;

  pix_t              pix_sel;
  logic [ROW_W-1:0]  row_sel;
  logic [CW-1:0]     col_sel;
  logic [31:0]       col_wide;
  logic              last_sel;

  // The config port is always ready; the user must write only while idle (not enforced).
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign cfg_hit   = cfg_wr && ((cfg_index == CFG_IMAGE_ROWS) || (cfg_index == CFG_IMAGE_COLUMNS));

  // Effective frame size: zero acts as one, oversize saturates.
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_m1 = '0;
    end else if (rows_cfg_r > ROWS_CFG_W'(ROW_LIMIT)) begin
      rows_m1 = ROW_W'(ROW_LIMIT - 1);
    end else begin
      rows_m1 = ROW_W'(rows_cfg_r - ROWS_CFG_W'(1));
    end
    if (cols_cfg_r == '0) begin
      cols_m1 = '0;
    end else if ({2'b00, cols_cfg_r} > MAX_COLS_WIDE) begin
      cols_m1 = CW'(MAX_COLUMNS - 1);
    end else begin
      cols_m1 = CW'(cols_cfg_r - COLS_CFG_W'(1));
    end
  end

  // One pixel is in flight at a time, so the input is open only when idle.
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Results owed for the pixel at the current position, in raster order of output.
  always_comb begin
    pend_new[RES_CENTER] = (row_cnt_r != '0) && (col_cnt_r != '0);
    pend_new[RES_RIGHT]  = (row_cnt_r != '0) && (col_cnt_r == cols_m1);
    pend_new[RES_BOTTOM] = (row_cnt_r == rows_m1) && (col_cnt_r != '0);
    pend_new[RES_LAST]   = (row_cnt_r == rows_m1) && (col_cnt_r == cols_m1);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ROWS_CFG_W'(1);
      cols_cfg_r <= COLS_CFG_W'(1);
    end else if (cfg_wr) begin
      if (cfg_index == CFG_IMAGE_ROWS) begin
        rows_cfg_r <= cfg_data[ROWS_CFG_W-1:0];
      end
      if (cfg_index == CFG_IMAGE_COLUMNS) begin
        cols_cfg_r <= cfg_data[COLS_CFG_W-1:0];
      end
    end
  end

  // Frame position counters; any write to a size register restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (cfg_hit) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_acc) begin
      if (col_cnt_r == cols_m1) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_cnt_r == rows_m1) ? '0 : row_cnt_r + ROW_W'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  // The accepted pixel and its position are held for the whole sequence.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r       <= in_pixel_in;
      r_r        <= row_cnt_r;
      c_r        <= col_cnt_r;
      interior_r <= (row_cnt_r >= ROW_W'(2)) && (col_cnt_r >= CW'(2));
    end
  end

  // Line stores: read at accept, the data arrives in the READ state, where the
  // column is written back. The next read comes only after the sequencer has returned
  // to idle, so it always sees the new contents.
  dpna_line_store #(
    .DEPTH (MAX_COLUMNS),
    .AW    (CW)
  ) u_upper (
    .clk   (clk),
    .we    (state_r == ST_READ),
    .waddr (c_r),
    .wdata (mid_rd),
    .re    (in_acc),
    .raddr (col_cnt_r),
    .rdata (up_rd)
  );

  dpna_line_store #(
    .DEPTH (MAX_COLUMNS),
    .AW    (CW)
  ) u_middle (
    .clk   (clk),
    .we    (state_r == ST_READ),
    .waddr (c_r),
    .wdata (px_r),
    .re    (in_acc),
    .raddr (col_cnt_r),
    .rdata (mid_rd)
  );

  // The window shifts left by one column and takes the new column on the right.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (state_r == ST_READ) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i*3]   <= win_r[i*3+1];
        win_r[i*3+1] <= win_r[i*3+2];
      end
      win_r[WIN_UP_NEW]  <= up_rd;
      win_r[WIN_MID_NEW] <= mid_rd;
      win_r[WIN_BOT_NEW] <= px_r;
    end
  end

  // The mean pipeline runs freely on the window; its result is ready in EMIT.
  dpna_mean u_mean (
    .clk  (clk),
    .win  (win_r),
    .mean (mean)
  );

  // Sequencer: next state, pending results and output register loads.
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    load      = 1'b0;
    if (pend_r[RES_CENTER]) begin
      slot = RES_CENTER;
    end else if (pend_r[RES_RIGHT]) begin
      slot = RES_RIGHT;
    end else if (pend_r[RES_BOTTOM]) begin
      slot = RES_BOTTOM;
    end else begin
      slot = RES_LAST;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
          pend_nxt  = pend_new;
        end
      end
      ST_READ: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (pend_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          load     = 1'b1;
          pend_nxt = pend_r & (pend_r - pend_t'(1));
          if (pend_nxt == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        pend_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Payload of the result in the selected slot. Only a defective interior
  // center pixel takes the neighbour mean; everything else is copied.
  always_comb begin
    case (slot)
      RES_CENTER: begin
        pix_sel  = (interior_r && win_r[WIN_CENTER][PIX_W-1]) ? mean : win_r[WIN_CENTER];
        row_sel  = r_r - ROW_W'(1);
        col_sel  = c_r - CW'(1);
        last_sel = 1'b0;
      end
      RES_RIGHT: begin
        pix_sel  = win_r[WIN_MID_NEW];
        row_sel  = r_r - ROW_W'(1);
        col_sel  = c_r;
        last_sel = 1'b0;
      end
      RES_BOTTOM: begin
        pix_sel  = win_r[WIN_BOT_PREV];
        row_sel  = r_r;
        col_sel  = c_r - CW'(1);
        last_sel = 1'b0;
      end
      default: begin
        pix_sel  = win_r[WIN_BOT_NEW];
        row_sel  = r_r;
        col_sel  = c_r;
        last_sel = 1'b1;
      end
    endcase
    col_wide = 32'(col_sel);
  end

  // Output register: holds a finished result until the transaction completes,
  // while the input side may already take the next pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pixel_out  <= pix_sel;
      out_row        <= row_sel;
      out_column     <= col_wide[COL_OUT_W-1:0];
      out_frame_last <= last_sel;
    end
  end

  `DPNA_ASSERT_NEXT(a_accept_reads, in_acc, (state_r == ST_READ), "accepted pixel did not start a read")
  `DPNA_ASSERT_IMPL(a_idle_no_pending, (state_r == ST_IDLE), (pend_r == '0), "results left pending in idle")
  `DPNA_ASSERT_NEXT(a_window_hold, (state_r != ST_READ), $stable(win_r), "window moved outside the read step")
  `DPNA_ASSERT_IMPL(a_load_from_emit, $rose(out_valid), ($past(state_r) == ST_EMIT), "result loaded outside emit")

endmodule

// File: tb/tb.sv
// Self-checking testbench for defective_pixel_neighbour_average: a directed table, then
// random frames, each checked against a typed-in value or an in-bench mean correction model.
// Depends on dpna_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import dpna_pkg::*;

  localparam int LINE_DEPTH       = 1024;
  localparam int TOTAL_PIXELS     = 310;   // directed rows plus random pixels, in all
  localparam int SETTLE_CYCLES    = 16;    // covers one pixel's sequence and the emits of a row end
  localparam int LONG_HOLD_CYCLES = 200;
  localparam int END_WAIT_CYCLES  = 20000;

  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 4'd15;

  localparam pix_t PIX_MIN = 9'h100;
  localparam pix_t PIX_MAX = 9'h0FF;

  // One emitted pixel with its position in the frame.
  typedef struct packed {
    pix_t                 pixel;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] column;
    logic                 last;
  } placed_pixel_t;

  localparam placed_pixel_t NO_RESULT = '0;

  typedef enum logic [1:0] {
    STIM_PIXEL,
    STIM_PIXEL_KNOWN,
    STIM_REGISTER
  } stim_kind_t;

  typedef struct packed {
    stim_kind_t            kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    pix_t                  pixel;
    placed_pixel_t         known;
  } stim_row_t;

  localparam int NUM_DIRECTED = 27;

  // Directed table. Rows marked KNOWN carry their single result typed in; all other
  // pixel rows are checked against the model below.
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // Power-up sizes are one by one, so each pixel is a whole frame and is copied as is.
    '{STIM_PIXEL_KNOWN, '0, '0, PIX_MIN, '{PIX_MIN, 12'd0, 10'd0, 1'b1}},
    '{STIM_PIXEL_KNOWN, '0, '0, PIX_MAX, '{PIX_MAX, 12'd0, 10'd0, 1'b1}},
    '{STIM_PIXEL_KNOWN, '0, '0, 9'sd0, '{9'sd0, 12'd0, 10'd0, 1'b1}},
    // A size of zero behaves as a size of one.
    '{STIM_REGISTER, CFG_IMAGE_ROWS, 13'd0, 9'sd0, NO_RESULT},
    '{STIM_REGISTER, CFG_IMAGE_COLUMNS, 13'd0, 9'sd0, NO_RESULT},
    '{STIM_PIXEL_KNOWN, '0, '0, -9'sd1, '{-9'sd1, 12'd0, 10'd0, 1'b1}},
    // 3x3 frame: negative border pixels stay, the negative center takes the mean of
    // its five positive neighbors. The write to the unused index lands mid-frame and
    // must not restart the frame.
    '{STIM_REGISTER, CFG_IMAGE_ROWS, 13'd3, 9'sd0, NO_RESULT},
    '{STIM_REGISTER, CFG_IMAGE_COLUMNS, 13'd3, 9'sd0, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd10, NO_RESULT},
    '{STIM_PIXEL, '0, '0, -9'sd5, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd20, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd30, NO_RESULT},
    '{STIM_PIXEL, '0, '0, -9'sd1, NO_RESULT},
    '{STIM_REGISTER, CFG_UNUSED_INDEX, 13'h1FFF, 9'sd0, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd0, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd40, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd7, NO_RESULT},
    '{STIM_PIXEL, '0, '0, PIX_MIN, NO_RESULT},
    // Next frame follows without a write: a defective center with no positive neighbor.
    '{STIM_PIXEL, '0, '0, -9'sd1, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd0, NO_RESULT},
    '{STIM_PIXEL, '0, '0, -9'sd2, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd0, NO_RESULT},
    '{STIM_PIXEL, '0, '0, -9'sd3, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd0, NO_RESULT},
    '{STIM_PIXEL, '0, '0, -9'sd4, NO_RESULT},
    '{STIM_PIXEL, '0, '0, 9'sd0, NO_RESULT},
    '{STIM_PIXEL, '0, '0, -9'sd5, NO_RESULT}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pix_t                  in_pixel_in = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pix_t                  out_pixel_out;
  logic [ROW_W-1:0]      out_row;
  logic [COL_OUT_W-1:0]  out_column;
  logic                  out_frame_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  defective_pixel_neighbour_average #(
    .MAX_COLUMNS(LINE_DEPTH)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_row       (out_row),
    .out_column    (out_column),
    .out_frame_last(out_frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Model state: the two sizes, both line stores, the window and the raster position.
  logic [ROWS_CFG_W-1:0] rows_setting = ROWS_CFG_W'(1);
  logic [COLS_CFG_W-1:0] columns_setting = COLS_CFG_W'(1);
  pix_t                  upper_line [LINE_DEPTH];
  pix_t                  middle_line [LINE_DEPTH];
  pix_t                  window [3][3];
  int unsigned           row_pos;
  int unsigned           column_pos;

  // Corrected pixels that the block still owes, oldest first.
  placed_pixel_t awaited_pixels [$];

  int  error_count;
  int  pixels_sent;
  int  results_checked;
  int  settings_written;
  int  defects_replaced;
  int  sender_idle_pct;
  bit  long_hold_request;

  initial begin
    forever #6 clk = ~clk;
  end

  // Works out what one accepted pixel releases, in emission order, and advances the
  // raster position. Output runs one row and one column behind the input; the last
  // row goes out together with the row above it.
  function automatic int predict_corrections(input pix_t px,
                                             output placed_pixel_t results [RES_N]);
    int unsigned rows, cols, r, c, sum, count;
    int          n;
    pix_t        center;
    rows = (rows_setting == 0) ? 1 : (rows_setting > ROW_LIMIT) ? ROW_LIMIT : rows_setting;
    cols = (columns_setting == 0) ? 1 :
           (columns_setting > LINE_DEPTH) ? LINE_DEPTH : columns_setting;
    r = (row_pos >= rows) ? rows - 1 : row_pos;
    c = (column_pos >= cols) ? cols - 1 : column_pos;
    results = '{default: '0};
    n = 0;

    for (int i = 0; i < 3; i++) begin
      window[i][0] = window[i][1];
      window[i][1] = window[i][2];
    end
    window[0][2] = upper_line[c];
    window[1][2] = middle_line[c];
    window[2][2] = px;
    upper_line[c] = middle_line[c];
    middle_line[c] = px;

    if (r >= 1) begin
      if (c >= 1) begin
        center = window[1][1];
        // Only interior pixels are corrected; the center itself is negative, so it
        // never counts toward its own mean.
        if (r >= 2 && c >= 2 && center < 0) begin
          sum = 0;
          count = 0;
          for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
              if (window[i][j] > 0) begin
                sum += int'(window[i][j]);
                count++;
              end
            end
          end
          center = (count == 0) ? pix_t'(0) : pix_t'(sum / count);
          defects_replaced++;
        end
        results[n] = '{center, ROW_W'(r - 1), COL_OUT_W'(c - 1), 1'b0};
        n++;
      end
      if (c == cols - 1) begin
        results[n] = '{window[1][2], ROW_W'(r - 1), COL_OUT_W'(c), 1'b0};
        n++;
      end
    end
    if (r == rows - 1) begin
      if (c >= 1) begin
        results[n] = '{window[2][1], ROW_W'(r), COL_OUT_W'(c - 1), 1'b0};
        n++;
      end
      if (c == cols - 1) begin
        results[n] = '{px, ROW_W'(r), COL_OUT_W'(c), 1'b1};
        n++;
      end
    end

    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) begin
        r = 0;
      end
    end
    row_pos = r;
    column_pos = c;
    return n;
  endfunction

  function automatic pix_t random_pixel(input int unsigned defect_pct);
    if ($urandom_range(0, 99) < defect_pct) begin
      return ($urandom_range(0, 7) == 0) ? PIX_MIN : pix_t'($urandom_range(256, 511));
    end
    case ($urandom_range(0, 9))
      0: return pix_t'(0);
      1: return PIX_MAX;
      2: return pix_t'(1);
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one pixel and holds it until the block takes it. Valid stays high when the
  // next pixel follows directly, so it is never lowered and raised in the same step.
  task automatic send_pixel(input pix_t px, input bit use_known, input placed_pixel_t known);
    placed_pixel_t results [RES_N];
    int            n;
    int            gap;
    in_valid <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    n = predict_corrections(px, results);
    if (use_known) begin
      awaited_pixels.push_back(known);
    end else begin
      for (int k = 0; k < n; k++) awaited_pixels.push_back(results[k]);
    end
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering pixels, waits for every owed result, then lets a pixel that
  // releases nothing finish inside the block.
  task automatic await_idle();
    in_valid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Any write to a real register restarts the frame at row 0, column 0.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_IMAGE_ROWS: begin
        rows_setting = data[ROWS_CFG_W-1:0];
        row_pos = 0;
        column_pos = 0;
      end
      CFG_IMAGE_COLUMNS: begin
        columns_setting = data[COLS_CFG_W-1:0];
        row_pos = 0;
        column_pos = 0;
      end
      default: ;
    endcase
    settings_written++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // One frame setting: both sizes written while idle, then a stream of pixels. The
  // columns write carries random junk above bit 10, which the block must drop.
  task automatic run_frames(input int unsigned rows, input int unsigned cols,
                            input int unsigned count, input int unsigned defect_pct,
                            input bit hold_receiver);
    await_idle();
    write_register(CFG_IMAGE_ROWS, CFG_DATA_W'(rows));
    write_register(CFG_IMAGE_COLUMNS,
                   CFG_DATA_W'(cols) | (CFG_DATA_W'($urandom_range(0, 3)) << COLS_CFG_W));
    if (hold_receiver) begin
      long_hold_request = 1'b1;
    end
    repeat (count) send_pixel(random_pixel(defect_pct), 1'b0, NO_RESULT);
  endtask

  // Result checker: every transaction on the output channel is compared with the
  // oldest owed pixel. Sampling at the edge sees the values that made the handshake.
  always @(posedge clk) begin
    placed_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_pixels.size() == 0) begin
        $error("unexpected result: pixel %0d at row %0d column %0d",
               out_pixel_out, out_row, out_column);
        error_count++;
      end else begin
        want = awaited_pixels.pop_front();
        results_checked++;
        if (out_pixel_out !== want.pixel) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel, out_pixel_out);
          error_count++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          error_count++;
        end
        if (out_column !== want.column) begin
          $error("out_column: expected %0d, got %0d", want.column, out_column);
          error_count++;
        end
        if (out_frame_last !== want.last) begin
          $error("frame_last: expected %0d, got %0d", want.last, out_frame_last);
          error_count++;
        end
      end
    end
  end

  // Receiver pacing. Stall density changes from one random-length segment to the next,
  // including segments with no stall at all; most stalls are short, a few are long. On
  // request the receiver holds off for LONG_HOLD_CYCLES so the block backs up to its input.
  initial begin : receiver_pacing
    int hold_left;
    int segment_left;
    int stall_pct;
    hold_left = 0;
    segment_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (long_hold_request) begin
        long_hold_request = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (segment_left == 0) begin
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 10;
            default: stall_pct = 35;
          endcase
          segment_left = $urandom_range(20, 100);
        end
        segment_left--;
        if ($urandom_range(0, 99) < stall_pct) begin
          hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned rows, cols, count, defect_pct;
    int          phase;
    int          max_rows, max_cols;

    for (int k = 0; k < LINE_DEPTH; k++) begin
      upper_line[k] = '0;
      middle_line[k] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) window[i][j] = '0;
    end
    row_pos = 0;
    column_pos = 0;
    sender_idle_pct = 30;
    max_rows = 0;
    max_cols = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      case (DIRECTED[i].kind)
        STIM_REGISTER: begin
          await_idle();
          write_register(DIRECTED[i].index, DIRECTED[i].data);
        end
        STIM_PIXEL_KNOWN: send_pixel(DIRECTED[i].pixel, 1'b1, DIRECTED[i].known);
        default: send_pixel(DIRECTED[i].pixel, 1'b0, NO_RESULT);
      endcase
    end

    // Random frames. The first three settings are fixed: a larger frame streamed with
    // no sender gaps during the long receiver hold, then the widest and the tallest
    // settings, both past saturation. After that mostly whole small frames, with some
    // thin frames, some frames cut short by a new setting, and a few large sizes.
    phase = 0;
    while (pixels_sent < TOTAL_PIXELS) begin
      case ($urandom_range(0, 2))
        0: defect_pct = 10;
        1: defect_pct = 40;
        default: defect_pct = 90;
      endcase
      sender_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
      if (phase == 0) begin
        rows = 6;
        cols = 8;
        count = 48;
        sender_idle_pct = 0;
      end else if (phase == 1) begin
        rows = 1;
        cols = 2047;
        count = 40;
      end else if (phase == 2) begin
        rows = 8191;
        cols = 1;
        count = 40;
      end else begin
        case ($urandom_range(0, 9))
          6: begin
            if ($urandom_range(0, 1) == 0) begin
              rows = $urandom_range(1, 2);
              cols = $urandom_range(1, 6);
            end else begin
              rows = $urandom_range(1, 6);
              cols = $urandom_range(1, 2);
            end
            count = rows * cols * $urandom_range(2, 4);
          end
          7: begin
            rows = $urandom_range(3, 6);
            cols = $urandom_range(3, 8);
            count = $urandom_range(1, rows * cols - 1);
          end
          8: begin
            rows = 1;
            cols = ($urandom_range(0, 1) == 0) ? 1024 : $urandom_range(1025, 2047);
            count = $urandom_range(20, 40);
          end
          9: begin
            rows = ($urandom_range(0, 1) == 0) ? 4096 : $urandom_range(4097, 8191);
            cols = $urandom_range(1, 3);
            count = $urandom_range(20, 40);
          end
          default: begin
            rows = $urandom_range(3, 7);
            cols = $urandom_range(3, 9);
            count = rows * cols * $urandom_range(1, 2);
          end
        endcase
      end
      // The last setting streams only what is left of the pixel budget.
      if (count > TOTAL_PIXELS - pixels_sent) begin
        count = TOTAL_PIXELS - pixels_sent;
      end
      if (rows > max_rows) max_rows = rows;
      if (cols > max_cols) max_cols = cols;
      run_frames(rows, cols, count, defect_pct, phase == 0);
      phase++;
    end

    in_valid <= 1'b0;
    for (int k = 0; k < END_WAIT_CYCLES && awaited_pixels.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_pixels.size() != 0) begin
      $error("%0d results never arrived, oldest at row %0d column %0d",
             awaited_pixels.size(), awaited_pixels[0].row, awaited_pixels[0].column);
      error_count++;
    end

    $display("Run covered %0d pixels and %0d register writes; %0d results checked.",
             pixels_sent, settings_written, results_checked);
    $display("Interior defects replaced: %0d; largest setting %0d rows, %0d columns.",
             defects_replaced, max_rows, max_cols);
    if (error_count == 0) begin
      $display("defective_pixel_neighbour_average: match");
    end else begin
      $display("defective_pixel_neighbour_average: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $error("run timed out with %0d results outstanding", awaited_pixels.size());
    $display("defective_pixel_neighbour_average: mismatch");
    $finish;
  end

endmodule
